/* rtl/aes_pkg.sv */
// Package: AES constants, S-box and round helper functions.
package aes_pkg;
	localparam int StoreDepth = 60;

	localparam logic [1:0] KS128 = 2'd0;
	localparam logic [1:0] KS192 = 2'd1;

	localparam logic [2:0] RegKeySize = 3'd0;
	localparam logic [2:0] RegKey0 = 3'd1;
	localparam logic [2:0] RegKey1 = 3'd2;
	localparam logic [2:0] RegKey2 = 3'd3;
	localparam logic [2:0] RegKey3 = 3'd4;

	typedef struct packed {
		logic       start;
		logic [1:0] key_size;
	} kx_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} kx_sts_t;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[x];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// state as 128 bits, byte 0 in [127:120], column c = bytes 4c..4c+3
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[127 - 8*(4*c + r) -: 8] = sbox(s[127 - 8*(4*((c + r) % 4) + r) -: 8]);
		return t;
	endfunction

	function automatic logic [127:0] mix_cols(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3, al;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127 - 32*c -: 8];
			a1 = s[119 - 32*c -: 8];
			a2 = s[111 - 32*c -: 8];
			a3 = s[103 - 32*c -: 8];
			al = a0 ^ a1 ^ a2 ^ a3;
			t[127 - 32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
			t[119 - 32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
			t[111 - 32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
			t[103 - 32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
		end
		return t;
	endfunction
endpackage

/* rtl/aes_rk_ram.sv */
// Round-key store: 15 rows of four words for round reads, plus a word-wide copy for expansion.
module aes_rk_ram (
	input  logic        clk,
	input  logic        we,
	input  logic [5:0]  waddr,
	input  logic [31:0] wdata,
	input  logic [3:0]  rrow,
	output logic [127:0] rdata,
	input  logic [5:0]  raddr2,
	output logic [31:0] rdata2
);
	// wide copy for round reads, narrow copy for the expansion feedback
	logic [127:0] mem [15];
	logic [31:0]  mem2 [aes_pkg::StoreDepth];

	always_ff @(posedge clk) begin
		if (we) begin
			unique case (waddr[1:0])
				2'd0: mem[waddr[5:2]][127:96] <= wdata;
				2'd1: mem[waddr[5:2]][95:64] <= wdata;
				2'd2: mem[waddr[5:2]][63:32] <= wdata;
				default: mem[waddr[5:2]][31:0] <= wdata;
			endcase
			mem2[waddr] <= wdata;
		end
		rdata <= mem[rrow];
		rdata2 <= mem2[raddr2];
	end
endmodule

/* rtl/aes_key_exp.sv */
// Key expansion sequencer: writes the key words directly, then derives each further word from a read of the store.
module aes_key_exp (
	input  logic             clk,
	input  logic             arst_n,
	input  aes_pkg::kx_ctl_t ctl,
	input  logic [255:0]     key,
	output aes_pkg::kx_sts_t sts,
	output logic             we,
	output logic [5:0]       waddr,
	output logic [31:0]      wdata,
	output logic [5:0]       raddr,
	input  logic [31:0]      rdata
);
	logic [5:0] i_q, total_q;
	logic [3:0] nk_q;
	logic [3:0] ph_q;      // i mod nk
	logic [7:0] rc_q;
	logic [31:0] prev_q;
	logic busy_q, rd_q;
	logic [31:0] t;

	assign raddr = i_q - {2'd0, nk_q};
	assign waddr = i_q;
	assign sts.busy = busy_q;
	assign sts.done = busy_q && (i_q == total_q);

	always_comb begin
		t = prev_q;
		if (ph_q == 4'd0)
			t = aes_pkg::sub_word({prev_q[23:0], prev_q[31:24]}) ^ {rc_q, 24'd0};
		else if (nk_q == 4'd8 && ph_q == 4'd4)
			t = aes_pkg::sub_word(prev_q);
		if (i_q < {2'd0, nk_q})
			wdata = key[255 - 32*i_q[2:0] -: 32];
		else
			wdata = rdata ^ t;
	end
	assign we = busy_q && !sts.done && (rd_q || i_q < {2'd0, nk_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rd_q <= 1'b0;
			i_q <= '0;
			ph_q <= '0;
			nk_q <= 4'd4;
			total_q <= 6'd44;
			rc_q <= 8'h01;
			prev_q <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			rd_q <= 1'b0;
			i_q <= '0;
			ph_q <= '0;
			rc_q <= 8'h01;
			unique case (ctl.key_size)
				aes_pkg::KS128: begin nk_q <= 4'd4; total_q <= 6'd44; end
				aes_pkg::KS192: begin nk_q <= 4'd6; total_q <= 6'd52; end
				default: begin nk_q <= 4'd8; total_q <= 6'd60; end
			endcase
		end else if (sts.done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			if (i_q >= {2'd0, nk_q} && !rd_q) begin
				rd_q <= 1'b1;
			end else begin
				rd_q <= 1'b0;
				prev_q <= wdata;
				i_q <= i_q + 6'd1;
				if (ph_q == nk_q - 4'd1) ph_q <= '0;
				else ph_q <= ph_q + 4'd1;
				if (ph_q == 4'd0 && i_q >= {2'd0, nk_q}) rc_q <= aes_pkg::xtime(rc_q);
			end
		end
	end
endmodule

/* rtl/aes_block_encrypt_top.sv */
// Top level: AES-128/192/256 ECB encryption with APB key setup.
// Usage: write key_size (0x00) and key words (0x08..0x20, 64-bit data) while idle.
// Any such write marks the round keys stale; the next accepted item first
// runs key expansion (key words written directly, each generated word by a
// read-modify-write through the round-key store), then the rounds.
// An item passes through the accepting state, a whitening step, then one step
// per round, each fed by a registered round-key read.
// One item is in work at a time; the result waits in an output register while
// the next item is accepted, and that item's last round holds until the
// waiting result is taken.
module aes_block_encrypt_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] plain_high,
	input  logic [63:0] plain_low,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] cipher_high,
	output logic [63:0] cipher_low
);
	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StKey  = 2'd1;
	localparam logic [1:0] StRnd  = 2'd2;

	logic [1:0]   st_q;
	logic [1:0]   ksize_q;
	logic [63:0]  kw_q [4];
	logic         kexp_q;
	logic [127:0] s_q;
	logic [3:0]   rnd_q, nr;
	logic         kick_q;
	logic         ov_q;
	logic [127:0] out_q;
	logic         fin;

	aes_pkg::kx_ctl_t kctl;
	aes_pkg::kx_sts_t ksts;
	logic        kwe;
	logic [5:0]  kwa, kra;
	logic [31:0] kwd, krd;
	logic [127:0] rk;
	logic [3:0]   rrow;

	logic [2:0] reg_idx;
	logic wr;
	assign reg_idx = paddr[5:3];
	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_comb begin
		unique case (reg_idx)
			aes_pkg::RegKeySize: prdata = {62'd0, ksize_q};
			aes_pkg::RegKey0: prdata = kw_q[0];
			aes_pkg::RegKey1: prdata = kw_q[1];
			aes_pkg::RegKey2: prdata = kw_q[2];
			aes_pkg::RegKey3: prdata = kw_q[3];
			default: prdata = '0;
		endcase
	end

	always_comb begin
		unique case (ksize_q)
			aes_pkg::KS128: nr = 4'd10;
			aes_pkg::KS192: nr = 4'd12;
			default: nr = 4'd14;
		endcase
	end

	// input side is free whenever no item is in work
	assign in_ready = (st_q == StIdle);
	logic acc;
	assign acc = in_valid && in_ready;
	assign kctl.start = acc && !kexp_q;
	assign kctl.key_size = ksize_q;

	// last round completes once the output register is free or being emptied
	assign fin = (st_q == StRnd) && !kick_q && (rnd_q == nr) && (!ov_q || out_ready);

	aes_key_exp u_kx (
		.clk, .arst_n, .ctl(kctl),
		.key({kw_q[0], kw_q[1], kw_q[2], kw_q[3]}),
		.sts(ksts), .we(kwe), .waddr(kwa), .wdata(kwd), .raddr(kra), .rdata(krd)
	);

	// round-key row is selected ahead of the round that uses it, through the registered read;
	// the last row stays selected while the final round holds
	assign rrow = (st_q != StRnd) ? 4'd0 : (rnd_q == nr) ? rnd_q : rnd_q + 4'd1;

	aes_rk_ram u_ram (
		.clk, .we(kwe), .waddr(kwa), .wdata(kwd),
		.rrow(rrow), .rdata(rk), .raddr2(kra), .rdata2(krd)
	);

	logic [127:0] rnd_out;
	always_comb begin
		if (rnd_q == nr) rnd_out = aes_pkg::sub_shift(s_q) ^ rk;
		else rnd_out = aes_pkg::mix_cols(aes_pkg::sub_shift(s_q)) ^ rk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StIdle;
			ksize_q <= '0;
			for (int k = 0; k < 4; k++) kw_q[k] <= '0;
			kexp_q <= 1'b0;
			rnd_q <= '0;
			kick_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (wr) begin
				unique case (reg_idx)
					aes_pkg::RegKeySize: ksize_q <= pwdata[1:0];
					aes_pkg::RegKey0: kw_q[0] <= pwdata;
					aes_pkg::RegKey1: kw_q[1] <= pwdata;
					aes_pkg::RegKey2: kw_q[2] <= pwdata;
					aes_pkg::RegKey3: kw_q[3] <= pwdata;
					default: ;
				endcase
			end
			// any write inside the register map marks the round keys stale
			if (wr && reg_idx <= aes_pkg::RegKey3)
				kexp_q <= 1'b0;
			else if (st_q == StKey && ksts.done)
				kexp_q <= 1'b1;
			if (fin)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
			unique case (st_q)
				StIdle: begin
					kick_q <= acc && kexp_q;
					if (acc) begin
						st_q <= kexp_q ? StRnd : StKey;
						rnd_q <= '0;
						s_q <= {plain_high, plain_low};
					end
				end
				StKey: begin
					kick_q <= ksts.done;
					if (ksts.done) st_q <= StRnd;
				end
				StRnd: begin
					kick_q <= 1'b0;
					if (kick_q) begin
						// row 0 now read: add whitening key
						s_q <= s_q ^ rk;
						rnd_q <= 4'd1;
					end else if (rnd_q == nr) begin
						if (fin) begin
							out_q <= rnd_out;
							st_q <= StIdle;
						end
					end else begin
						s_q <= rnd_out;
						rnd_q <= rnd_q + 4'd1;
					end
				end
				default: begin
					kick_q <= 1'b0;
					st_q <= StIdle;
				end
			endcase
		end
	end

	assign out_valid = ov_q;
	assign cipher_high = out_q[127:64];
	assign cipher_low = out_q[63:0];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cipher_high) && $stable(cipher_low))
		else $error("result changed while stalled");
	a_kx: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == StRnd |-> !ksts.busy)
		else $error("rounds while key expansion busy");
	a_key: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == StRnd |-> kexp_q)
		else $error("rounds without expanded keys");
endmodule

/* test/tb_top.sv */
// Testbench for aes_block_encrypt_top: self-predicting AES-128/192/256 ECB checker.
`timescale 1ns / 1ps

module tb_top;
	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] plain_high;
	logic [63:0] plain_low;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] cipher_high;
	logic [63:0] cipher_low;

	aes_block_encrypt_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.plain_high(plain_high), .plain_low(plain_low),
		.out_valid(out_valid), .out_ready(out_ready),
		.cipher_high(cipher_high), .cipher_low(cipher_low)
	);

	// Shadow copy of the key registers, used by the cipher predictor.
	logic [1:0]   key_size_q;
	logic [63:0]  key_regs [4];
	logic [7:0]   sbox_lut [256];

	logic [127:0] cipher_queue [$];
	int           mismatches;
	int           send_idle_pct;
	int           recv_idle_pct;
	int           hold_off;	// receiver stall, in cycles

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog.
	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

	// ---------------------------------------------------------------
	// Predictor: GF(2^8) math, S-box built from field inverse + affine
	// ---------------------------------------------------------------
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
		return (x << n) | (x >> (8 - n));
	endfunction

	task automatic build_sbox();
		logic [7:0] inv;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h00;
			for (int y = 1; y < 256; y++)
				if (gf_mul(x[7:0], y[7:0]) == 8'h01)
					inv = y[7:0];
			sbox_lut[x] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3)
				^ rotl8(inv, 4) ^ 8'h63;
		end
	endtask

	function automatic logic [7:0] byte_of(input logic [127:0] s, input int b);
		return s[127 - 8*b -: 8];
	endfunction

	function automatic logic [31:0] subst_word(input logic [31:0] w);
		return {sbox_lut[w[31:24]], sbox_lut[w[23:16]], sbox_lut[w[15:8]], sbox_lut[w[7:0]]};
	endfunction

	// Full encryption of one block under the shadow key.
	function automatic logic [127:0] aes_encrypt(input logic [127:0] blk);
		logic [31:0]  w [60];
		logic [31:0]  t;
		logic [7:0]   rc;
		logic [127:0] s, n;
		logic [7:0]   a0, a1, a2, a3, al;
		int           nk, nr;
		nk = (key_size_q >= 2) ? 8 : 4 + 2 * key_size_q;
		nr = nk + 6;
		rc = 8'h01;
		for (int i = 0; i < nk; i++)
			w[i] = i[0] ? key_regs[i >> 1][31:0] : key_regs[i >> 1][63:32];
		for (int i = nk; i < 4 * (nr + 1); i++) begin
			t = w[i - 1];
			if (i % nk == 0) begin
				t = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = gf_mul(rc, 8'h02);
			end else if (nk == 8 && i % nk == 4) begin
				t = subst_word(t);
			end
			w[i] = w[i - nk] ^ t;
		end
		s = blk ^ {w[0], w[1], w[2], w[3]};
		for (int rnd = 1; rnd <= nr; rnd++) begin
			// SubBytes + ShiftRows
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					n[127 - 8*(4*c + r) -: 8] = sbox_lut[byte_of(s, 4*((c + r) % 4) + r)];
			s = n;
			if (rnd != nr) begin
				for (int c = 0; c < 4; c++) begin
					a0 = byte_of(s, 4*c);
					a1 = byte_of(s, 4*c + 1);
					a2 = byte_of(s, 4*c + 2);
					a3 = byte_of(s, 4*c + 3);
					al = a0 ^ a1 ^ a2 ^ a3;
					n[127 - 8*(4*c)     -: 8] = a0 ^ al ^ gf_mul(a0 ^ a1, 8'h02);
					n[127 - 8*(4*c + 1) -: 8] = a1 ^ al ^ gf_mul(a1 ^ a2, 8'h02);
					n[127 - 8*(4*c + 2) -: 8] = a2 ^ al ^ gf_mul(a2 ^ a3, 8'h02);
					n[127 - 8*(4*c + 3) -: 8] = a3 ^ al ^ gf_mul(a3 ^ a0, 8'h02);
				end
				s = n;
			end
			s ^= {w[4*rnd], w[4*rnd + 1], w[4*rnd + 2], w[4*rnd + 3]};
		end
		return s;
	endfunction

	// ---------------------------------------------------------------
	// Result checker
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		logic [127:0] exp_blk;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (cipher_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected item: %h %h", cipher_high, cipher_low);
				end else begin
					exp_blk = cipher_queue.pop_front();
					if (cipher_high !== exp_blk[127:64] || cipher_low !== exp_blk[63:0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("cipher mismatch: exp %h %h got %h %h",
								exp_blk[127:64], exp_blk[63:0], cipher_high, cipher_low);
					end
				end
			end
		end
	end

	// Receiver ready generation, with the long hold-off counted here.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_off > 0) begin
				hold_off--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// ---------------------------------------------------------------
	// Shared driver tasks
	// ---------------------------------------------------------------
	// APB write: setup then access; register index is paddr / 8.
	task automatic reg_write(input int idx, input logic [63:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 6'(idx * 8);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == aes_pkg::RegKeySize)
			key_size_q = val[1:0];
		else if (idx >= aes_pkg::RegKey0 && idx <= aes_pkg::RegKey3)
			key_regs[idx - 1] = val;
		// other indexes: ignored by the block
	endtask

	task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid   <= 1'b1;
		plain_high <= hi;
		plain_low  <= lo;
		do @(posedge clk); while (!in_ready);
		cipher_queue.push_back(aes_encrypt({hi, lo}));
	endtask

	// Quiesce: no item in flight, then margin for the key expansion path.
	task automatic drain();
		in_valid <= 1'b0;
		while (cipher_queue.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic load_key(input logic [1:0] ks, input logic [63:0] k0, input logic [63:0] k1,
		input logic [63:0] k2, input logic [63:0] k3);
		reg_write(aes_pkg::RegKeySize, {62'd0, ks});
		reg_write(aes_pkg::RegKey0, k0);
		reg_write(aes_pkg::RegKey1, k1);
		reg_write(aes_pkg::RegKey2, k2);
		reg_write(aes_pkg::RegKey3, k3);
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	// Extreme keys and blocks over every key size, incl. size code three.
	task automatic test_directed();
		logic [63:0] ones;
		ones = '1;
		send_block(64'h0, 64'h0);	// reset key: all-zero AES-128
		send_block(ones, ones);
		drain();
		load_key(aes_pkg::KS128, 64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 0, 0);
		send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
		drain();
		load_key(aes_pkg::KS128, ones, ones, ones, ones);
		send_block(64'h0, ones);
		send_block(ones, 64'h0);
		drain();
		load_key(aes_pkg::KS192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h1011121314151617, ones);
		send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
		send_block(ones, ones);
		drain();
		load_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h1011121314151617, 64'h18191a1b1c1d1e1f);
		send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
		send_block(64'h0, 64'h0);
		drain();
		// size code three behaves as 256 bits
		reg_write(aes_pkg::RegKeySize, 64'd3);
		send_block(ones, 64'h0123456789abcdef);
		drain();
		// rewrite of an unchanged value forces re-expansion, same result
		reg_write(aes_pkg::RegKey0, key_regs[0]);
		send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
		drain();
		// write beyond the register map is ignored
		reg_write(5, ones);
		send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
		drain();
	endtask

	// Random keys and blocks; runs once per idle profile.
	task automatic test_random(input int s_pct, input int r_pct);
		logic [63:0] k [4];
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int ks = 0; ks < 4; ks++) begin
			for (int j = 0; j < 4; j++)
				k[j] = ($urandom_range(7) == 0) ? {64{ks[0]}} : rand64();
			load_key(ks[1:0], k[0], k[1], k[2], k[3]);
			for (int i = 0; i < 32; i++)
				send_block(rand64(), rand64());
			drain();
		end
	endtask

	// Long receiver stall while the sender keeps offering items.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_key(2'd2, rand64(), rand64(), rand64(), rand64());
		hold_off = 400;
		for (int i = 0; i < 12; i++)
			send_block(rand64(), rand64());
		drain();
	endtask

	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		plain_high    = '0;
		plain_low     = '0;
		out_ready     = 1'b0;
		mismatches    = 0;
		hold_off      = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		key_size_q    = aes_pkg::KS128;
		for (int j = 0; j < 4; j++)
			key_regs[j] = '0;
		build_sbox();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(36, 81);
		test_random(81, 36);
		test_random(0, 0);
		test_backpressure();

		if (mismatches == 0 && cipher_queue.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
